### rtl/aes_pkg.sv
// AES package: payload types, sequencer states, register indexes, S-box and GF helpers.
// Used by aes_round_unit and aes_block_cipher.
package aes_pkg;

  localparam int unsigned RoundKeyWordsDef = 60;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegKeyLen = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey0   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey1   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey2   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKey3   = 3'd4;

  localparam logic [1:0] KeyLenBad = 2'd3;
  localparam logic       CmdDec    = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
    logic        status;
  } aes_out_t;

  typedef enum logic [2:0] {
    StIdle, StExpand, StRdKey, StRound, StDone
  } aes_state_e;

  // Round unit control from the sequencer.
  typedef struct packed {
    logic load;    // load block and do initial key add
    logic step;    // one round
    logic last;    // final round (no mix)
    logic dec;
  } aes_rctl_t;

  localparam logic [7:0] SBOX [256] = '{
   8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
   8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
   8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
   8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
   8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
   8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
   8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
   8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
   8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
   8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
   8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
   8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
   8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
   8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
   8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
   8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] ISBOX [256] = '{
   8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
   8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
   8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
   8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
   8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
   8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
   8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
   8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
   8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
   8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
   8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
   8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
   8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
   8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
   8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
   8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

### rtl/aes_key_mem.sv
// Round-key word memory: one write port, one registered read port.
// Depends on nothing beyond its parameter.
module aes_key_mem #(
  parameter int unsigned Depth = 60
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [31:0]              wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [31:0]              rdata_o
);
  logic [31:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/aes_round.sv
// Shared AES round unit: one forward or inverse round per step over a state register.
// Depends on aes_pkg (S-boxes, xtime, control struct).
module aes_round_unit (
  input  logic                clk_i,
  input  aes_pkg::aes_rctl_t  ctl_i,
  input  logic [127:0]        blk_i,
  input  logic [127:0]        rkey_i,
  output logic [127:0]        state_o
);
  import aes_pkg::*;

  logic [127:0] state_q, state_d;
  logic [7:0]   s_b [16];
  logic [7:0]   sh_b [16];
  logic [7:0]   mx_b [16];
  logic [127:0] sh_w, mx_w, ark_w;

  function automatic logic [7:0] mul_e(input logic [7:0] v);  // x14
    logic [7:0] v2, v4, v8;
    v2 = xtime(v); v4 = xtime(v2); v8 = xtime(v4);
    mul_e = v8 ^ v4 ^ v2;
  endfunction
  function automatic logic [7:0] mul_b(input logic [7:0] v);  // x11
    logic [7:0] v2, v4, v8;
    v2 = xtime(v); v4 = xtime(v2); v8 = xtime(v4);
    mul_b = v8 ^ v2 ^ v;
  endfunction
  function automatic logic [7:0] mul_d(input logic [7:0] v);  // x13
    logic [7:0] v2, v4, v8;
    v2 = xtime(v); v4 = xtime(v2); v8 = xtime(v4);
    mul_d = v8 ^ v4 ^ v;
  endfunction
  function automatic logic [7:0] mul_9(input logic [7:0] v);
    logic [7:0] v2, v4, v8;
    v2 = xtime(v); v4 = xtime(v2); v8 = xtime(v4);
    mul_9 = v8 ^ v;
  endfunction

  // byte k sits at bits 127-8k
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      s_b[k] = state_q[127-8*k -: 8];
    end
    // sub bytes and shift rows, byte index r + 4c
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctl_i.dec) begin
          sh_b[r + 4*((c + r) % 4)] = ISBOX[s_b[r + 4*c]];
        end else begin
          sh_b[r + 4*c] = SBOX[s_b[r + 4*((c + r) % 4)]];
        end
      end
    end
    for (int k = 0; k < 16; k++) begin
      sh_w[127-8*k -: 8] = sh_b[k];
    end
    ark_w = sh_w ^ rkey_i;
    // column mix: forward on sub/shift result, inverse after key add
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctl_i.dec) begin
          mx_b[4*c + r] = mul_e(ark_w[127-8*(4*c + r) -: 8])
                        ^ mul_b(ark_w[127-8*(4*c + (r+1)%4) -: 8])
                        ^ mul_d(ark_w[127-8*(4*c + (r+2)%4) -: 8])
                        ^ mul_9(ark_w[127-8*(4*c + (r+3)%4) -: 8]);
        end else begin
          mx_b[4*c + r] = xtime(sh_b[4*c + r])
                        ^ xtime(sh_b[4*c + (r+1)%4]) ^ sh_b[4*c + (r+1)%4]
                        ^ sh_b[4*c + (r+2)%4] ^ sh_b[4*c + (r+3)%4];
        end
      end
    end
    for (int k = 0; k < 16; k++) begin
      mx_w[127-8*k -: 8] = mx_b[k];
    end
  end

  // state update
  always_comb begin
    state_d = state_q;
    if (ctl_i.load) begin
      state_d = blk_i ^ rkey_i;
    end else if (ctl_i.step) begin
      if (ctl_i.last) begin
        state_d = ark_w;
      end else if (ctl_i.dec) begin
        state_d = mx_w;
      end else begin
        state_d = mx_w ^ rkey_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign state_o = state_q;
endmodule

### rtl/aes_block_cipher.sv
// AES block cipher top level: config registers, key expansion and round sequencer.
// Depends on aes_pkg, aes_key_mem and aes_round_unit.
//
// Usage:
//  Configuration: cfg_we_i with cfg_idx_i/cfg_data_i writes one register per cycle
//  (0 key length code, 1..4 key words). Any write, even to an unused index, forces
//  a fresh key expansion before the next block. Write only while busy_o is low.
//  Command: a word is taken when start_i is high and busy_o is low; busy_o stays
//  high until the result word is out. The result word is on result_o for one cycle
//  with done_o high; the receiver cannot stall it.
//  Sequence: after the key is expanded, each of the Nr+1 key additions (Nr = 10,
//  12 or 14) reads its four key words one at a time through the one read port of
//  the key memory, then waits in the round stage for the last read to land and
//  runs the shared round unit; then done. A new word can be taken in the cycle
//  after done, so one block is in flight at a time. Key expansion runs one
//  word per cycle on the first block after reset or a configuration write.
//  Invalid key length code: the sequencer goes from idle straight to done, with
//  status 1 and zero data. Key words beyond a small key memory read as zero.
//  Reset: configuration registers clear to zero, the sequencer goes idle, the
//  schedule is marked stale; the key memory is undefined until expanded.
module aes_block_cipher #(
  parameter int unsigned RoundKeyWords = aes_pkg::RoundKeyWordsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [aes_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [aes_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                               start_i,
  input  aes_pkg::aes_in_t                   cmd_i,
  output logic                               busy_o,
  output logic                               done_o,
  output aes_pkg::aes_out_t                  result_o
);
  import aes_pkg::*;

  localparam int unsigned AddrW = $clog2(RoundKeyWords);

  aes_state_e   state_q, state_d;
  logic [1:0]   klen_q;
  logic [63:0]  key_q [4];
  logic         sched_q, sched_d;
  logic         dec_q, dec_d;
  logic         bad_q, bad_d;
  logic [127:0] blk_q, blk_d;
  logic [5:0]   widx_q, widx_d;      // key expansion word index, also key memory write address
  logic [3:0]   round_q, round_d;
  logic [1:0]   col_q, col_d;
  logic [127:0] rk_q, rk_d;
  logic         rvld_q, rvld_d;      // memory read pending
  logic         rok_q, rok_d;        // pending read address lies inside the memory
  logic [1:0]   rcol_q, rcol_d;
  logic [255:0] win_q, win_d;        // last nk words, newest at low end
  logic [7:0]   rcon_q, rcon_d;
  logic [2:0]   kmod_q, kmod_d;      // widx mod nk

  logic [3:0]   nr_w;
  logic [3:0]   nk_w;
  logic [5:0]   total_w;
  logic         mem_we;
  logic [31:0]  mem_wd, mem_rd;
  logic [5:0]   raddr6;
  aes_rctl_t    rctl;
  logic [127:0] st_w;
  logic [31:0]  t_w, prev_w, old_w, nw_w;

  assign nk_w    = 4'd4 + {1'b0, klen_q, 1'b0};
  assign nr_w    = nk_w + 4'd6;
  assign total_w = {nr_w, 2'b00} + 6'd4;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= '0;
      for (int k = 0; k < 4; k++) key_q[k] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegKeyLen: klen_q   <= cfg_data_i[1:0];
        RegKey0:   key_q[0] <= cfg_data_i;
        RegKey1:   key_q[1] <= cfg_data_i;
        RegKey2:   key_q[2] <= cfg_data_i;
        RegKey3:   key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // key expansion word: window holds w[i-nk..i-1], w[i-1] at bits 31:0
  always_comb begin
    prev_w = win_q[31:0];
    unique case (nk_w)
      4'd4:    old_w = win_q[127:96];
      4'd6:    old_w = win_q[191:160];
      default: old_w = win_q[255:224];
    endcase
    if (kmod_q == 3'd0) begin
      t_w = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rcon_q, 24'h0};
    end else if (nk_w == 4'd8 && kmod_q == 3'd4) begin
      t_w = sub_word(prev_w);
    end else begin
      t_w = prev_w;
    end
    if (widx_q < {2'b00, nk_w}) begin
      nw_w = widx_q[0] ? key_q[widx_q[2:1]][31:0] : key_q[widx_q[2:1]][63:32];
    end else begin
      nw_w = old_w ^ t_w;
    end
  end

  assign mem_wd = nw_w;

  // sequencer
  always_comb begin
    state_d = state_q;
    sched_d = sched_q;
    dec_d   = dec_q;
    bad_d   = bad_q;
    blk_d   = blk_q;
    widx_d  = widx_q;
    round_d = round_q;
    col_d   = col_q;
    rk_d    = rk_q;
    rvld_d  = 1'b0;
    rok_d   = rok_q;
    rcol_d  = col_q;
    win_d   = win_q;
    rcon_d  = rcon_q;
    kmod_d  = kmod_q;
    mem_we  = 1'b0;
    raddr6  = {round_q, col_q};
    rctl    = '0;
    rctl.dec = dec_q;
    busy_o  = (state_q != StIdle);
    done_o  = 1'b0;
    if (rvld_q) begin
      rk_d[127-32*rcol_q -: 32] = rok_q ? mem_rd : 32'd0;
    end
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          dec_d  = cmd_i.cmd;
          blk_d  = {cmd_i.block_hi, cmd_i.block_lo};
          bad_d  = (klen_q == KeyLenBad);
          widx_d = '0;
          kmod_d = '0;
          rcon_d = 8'h01;
          col_d  = '0;
          round_d = (cmd_i.cmd == CmdDec) ? nr_w : 4'd0;
          if (klen_q == KeyLenBad) state_d = StDone;
          else if (!sched_q)       state_d = StExpand;
          else                     state_d = StRdKey;
        end
      end
      StExpand: begin
        mem_we = ({26'd0, widx_q} < RoundKeyWords);
        win_d  = {win_q[223:0], nw_w};
        if (widx_q >= {2'b00, nk_w} && kmod_q == 3'd0) rcon_d = xtime(rcon_q);
        kmod_d = (kmod_q == nk_w[2:0] - 3'd1 || (nk_w == 4'd8 && kmod_q == 3'd7))
                 ? 3'd0 : kmod_q + 3'd1;
        widx_d = widx_q + 6'd1;
        if (widx_q == total_w - 6'd1) begin
          sched_d = 1'b1;
          state_d = StRdKey;
        end
      end
      StRdKey: begin
        // issue four reads, then run one round
        rvld_d = 1'b1;
        rok_d  = ({26'd0, raddr6} < RoundKeyWords);
        rcol_d = col_q;
        col_d  = col_q + 2'd1;
        if (col_q == 2'd3) state_d = StRound;
      end
      StRound: begin
        if (!rvld_q) begin
          rctl.load = (dec_q ? (round_q == nr_w) : (round_q == 4'd0));
          rctl.step = !rctl.load;
          rctl.last = (dec_q ? (round_q == 4'd0) : (round_q == nr_w));
          if (rctl.last) begin
            state_d = StDone;
          end else begin
            round_d = dec_q ? round_q - 4'd1 : round_q + 4'd1;
            state_d = StRdKey;
          end
        end
      end
      StDone: begin
        done_o  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    if (cfg_we_i) sched_d = 1'b0;
  end

  logic [AddrW-1:0] waddr, raddr;
  assign waddr = widx_q[AddrW-1:0];
  assign raddr = raddr6[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sched_q <= 1'b0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sched_q <= sched_d;
      rvld_q  <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dec_q   <= dec_d;
    bad_q   <= bad_d;
    blk_q   <= blk_d;
    widx_q  <= widx_d;
    round_q <= round_d;
    col_q   <= col_d;
    rk_q    <= rk_d;
    rok_q   <= rok_d;
    rcol_q  <= rcol_d;
    win_q   <= win_d;
    rcon_q  <= rcon_d;
    kmod_q  <= kmod_d;
  end

  aes_key_mem #(.Depth(RoundKeyWords)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (mem_wd),
    .raddr_i (raddr),
    .rdata_o (mem_rd)
  );

  aes_round_unit u_round (
    .clk_i   (clk_i),
    .ctl_i   (rctl),
    .blk_i   (blk_q),
    .rkey_i  (rk_q),
    .state_o (st_w)
  );

  assign result_o.result_hi = bad_q ? 64'd0 : st_w[127:64];
  assign result_o.result_lo = bad_q ? 64'd0 : st_w[63:0];
  assign result_o.status    = bad_q;

`ifndef SYNTHESIS
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done pulse longer than one cycle");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !done_o) |=> busy_o) else $error("busy dropped before result");
  a_sched_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !sched_q) else $error("schedule kept after config write");
`endif
endmodule
